@@ rtl/core/kcore_decomposition_assert.svh @@
// Assertion macros shared by the k-core decomposition RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef KCORE_DECOMPOSITION_ASSERT_SVH
`define KCORE_DECOMPOSITION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kcd_pkg.sv @@
// Shared types and constants of the k-core decomposition block.
// No dependencies; used by the controller, the datapath and the top level.
package kcd_pkg;

    localparam int NODE_W = 6;
    localparam int CORE_W = 11;
    localparam int CFG_W  = 7;
    localparam int CFG_RESET = 64;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic              has_edge;
        logic              last_item;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] rank;
        logic [NODE_W-1:0] node;
        logic [CORE_W-1:0] core_number;
        logic              dropped;
        logic              last_result;
    } t_out_item;

    // Controller phases, one-hot.
    typedef enum logic [35:0] {
        S_IDLE     = 36'd1 << 0,
        S_DCLR     = 36'd1 << 1,
        S_CNT_RD   = 36'd1 << 2,
        S_CNT_CHK  = 36'd1 << 3,
        S_CNT_WR   = 36'd1 << 4,
        S_MX_RD    = 36'd1 << 5,
        S_MX_UP    = 36'd1 << 6,
        S_BCLR     = 36'd1 << 7,
        S_BC_RD    = 36'd1 << 8,
        S_BC_RB    = 36'd1 << 9,
        S_BC_WR    = 36'd1 << 10,
        S_PF_RD    = 36'd1 << 11,
        S_PF_WR    = 36'd1 << 12,
        S_PL_RD    = 36'd1 << 13,
        S_PL_RB    = 36'd1 << 14,
        S_PL_WR    = 36'd1 << 15,
        S_SH_RD    = 36'd1 << 16,
        S_SH_WR    = 36'd1 << 17,
        S_PK_RV    = 36'd1 << 18,
        S_PK_RD    = 36'd1 << 19,
        S_PK_DV    = 36'd1 << 20,
        S_PK_E     = 36'd1 << 21,
        S_PK_EC    = 36'd1 << 22,
        S_PK_DU    = 36'd1 << 23,
        S_PK_BW    = 36'd1 << 24,
        S_PK_W     = 36'd1 << 25,
        S_PK_PU    = 36'd1 << 26,
        S_PK_PW    = 36'd1 << 27,
        S_PK_SW    = 36'd1 << 28,
        S_PK_UPD   = 36'd1 << 29,
        S_PK_EN    = 36'd1 << 30,
        S_PK_NEXT  = 36'd1 << 31,
        S_OUT_RV   = 36'd1 << 32,
        S_OUT_RD   = 36'd1 << 33,
        S_OUT_LD   = 36'd1 << 34,
        S_OUT_WT   = 36'd1 << 35
    } t_state;

    typedef struct packed {
        t_state phase;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic last_i;
        logic last_e;
        logic last_d;
        logic total_zero;
        logic edge_hit;
        logic du_gt;
        logic w_eq_u;
        logic out_taken;
    } t_status;

endpackage

@@ rtl/core/kcd_ctrl.sv @@
// Sequencing state machine of the k-core decomposition block.
// Depends on kcd_pkg; drives the phase command of kcd_datapath.
module kcd_ctrl
    import kcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // Next phase from the current phase and the datapath status.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_status.in_last) n_state = S_DCLR;
            S_DCLR:    if (i_status.last_i) begin
                n_state = i_status.total_zero ? S_MX_RD : S_CNT_RD;
            end
            S_CNT_RD:  n_state = S_CNT_CHK;
            S_CNT_CHK: n_state = S_CNT_WR;
            S_CNT_WR:  n_state = i_status.last_e ? S_MX_RD : S_CNT_RD;
            S_MX_RD:   n_state = S_MX_UP;
            S_MX_UP:   n_state = i_status.last_i ? S_BCLR : S_MX_RD;
            S_BCLR:    if (i_status.last_d) n_state = S_BC_RD;
            S_BC_RD:   n_state = S_BC_RB;
            S_BC_RB:   n_state = S_BC_WR;
            S_BC_WR:   n_state = i_status.last_i ? S_PF_RD : S_BC_RD;
            S_PF_RD:   n_state = S_PF_WR;
            S_PF_WR:   n_state = i_status.last_d ? S_PL_RD : S_PF_RD;
            S_PL_RD:   n_state = S_PL_RB;
            S_PL_RB:   n_state = S_PL_WR;
            S_PL_WR:   n_state = i_status.last_i ? S_SH_RD : S_PL_RD;
            S_SH_RD:   n_state = S_SH_WR;
            S_SH_WR:   n_state = i_status.last_d ? S_PK_RV : S_SH_RD;
            S_PK_RV:   n_state = S_PK_RD;
            S_PK_RD:   n_state = S_PK_DV;
            S_PK_DV:   n_state = i_status.total_zero ? S_PK_NEXT : S_PK_E;
            S_PK_E:    n_state = S_PK_EC;
            S_PK_EC:   n_state = i_status.edge_hit ? S_PK_DU : S_PK_EN;
            S_PK_DU:   n_state = i_status.du_gt ? S_PK_BW : S_PK_EN;
            S_PK_BW:   n_state = S_PK_W;
            S_PK_W:    n_state = i_status.w_eq_u ? S_PK_UPD : S_PK_PU;
            S_PK_PU:   n_state = S_PK_PW;
            S_PK_PW:   n_state = S_PK_SW;
            S_PK_SW:   n_state = S_PK_UPD;
            S_PK_UPD:  n_state = S_PK_EN;
            S_PK_EN:   n_state = i_status.last_e ? S_PK_NEXT : S_PK_E;
            S_PK_NEXT: n_state = i_status.last_i ? S_OUT_RV : S_PK_RV;
            S_OUT_RV:  n_state = S_OUT_RD;
            S_OUT_RD:  n_state = S_OUT_LD;
            S_OUT_LD:  n_state = S_OUT_WT;
            S_OUT_WT:  if (i_status.out_taken) begin
                n_state = i_status.last_i ? S_IDLE : S_OUT_RV;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.phase = r_state;

endmodule

@@ rtl/core/kcd_datapath.sv @@
// Datapath of the k-core decomposition block: entry, degree, bucket,
// position and order memories, loop counters and the output register.
// Depends on kcd_pkg; controlled by kcd_ctrl.
module kcd_datapath
    import kcd_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int DW  = EW;
    localparam int BKT_DEPTH = MAX_ENTRIES + 1;

    t_state phase;

    // Control and loop registers.
    logic [CFG_W-1:0] r_cfg;
    logic [EW-1:0]    r_total;
    logic             r_ovf;
    logic [NW-1:0]    r_i;
    logic [EAW-1:0]   r_e;
    logic [DW-1:0]    r_d;
    logic [DW-1:0]    r_maxd;
    logic [NCW-1:0]   r_acc;
    logic             r_out_valid;

    // Payload registers of the peeling step.
    logic [NW-1:0]  r_v;
    logic [DW-1:0]  r_dv;
    logic [NW-1:0]  r_u;
    logic [DW-1:0]  r_du;
    logic [NCW-1:0] r_bv;
    logic [NW-1:0]  r_w;
    logic [NW-1:0]  r_pu;
    logic [NW-1:0]  r_pwp;
    t_out_item      r_out;

    // Memories and their registered read data.
    logic [2*NODE_W-1:0] m_edge [MAX_ENTRIES];
    logic [DW-1:0]       m_deg  [MAX_NODES];
    logic [NCW-1:0]      m_bkt  [BKT_DEPTH];
    logic [NW-1:0]       m_pos  [MAX_NODES];
    logic [NW-1:0]       m_ord  [MAX_NODES];
    logic [2*NODE_W-1:0] r_edge_q;
    logic [DW-1:0]       r_deg_q;
    logic [NCW-1:0]      r_bkt_q;
    logic [NW-1:0]       r_pos_q;
    logic [NW-1:0]       r_ord_q;

    // Memory port controls.
    logic                edge_we;
    logic [EAW-1:0]      edge_wa;
    logic                deg_we;
    logic [NW-1:0]       deg_wa;
    logic [DW-1:0]       deg_wd;
    logic [NW-1:0]       deg_ra;
    logic                bkt_we;
    logic [DW-1:0]       bkt_wa;
    logic [NCW-1:0]      bkt_wd;
    logic [DW-1:0]       bkt_ra;
    logic                pos_we;
    logic [NW-1:0]       pos_wa;
    logic [NW-1:0]       pos_wd;
    logic [NW-1:0]       pos_ra;
    logic                ord_we;
    logic [NW-1:0]       ord_wa;
    logic [NW-1:0]       ord_wd;
    logic [NW-1:0]       ord_ra;

    logic [CFG_W-1:0]  n_full;
    logic [NW-1:0]     n_last;
    logic              in_take;
    logic              in_ok;
    logic [NODE_W-1:0] e_src;
    logic [NODE_W-1:0] e_tgt;
    logic              e_ok;
    logic              last_i;
    logic              last_e;
    logic              last_d;
    logic              out_taken;

    assign phase = i_cmd.phase;

    // Active node count, clamped into 1..MAX_NODES.
    always_comb begin
        if (r_cfg == '0) begin
            n_full = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_NODES)) begin
            n_full = CFG_W'(MAX_NODES);
        end else begin
            n_full = r_cfg;
        end
    end
    assign n_last = NW'(n_full - CFG_W'(1));

    // Input handshake and entry check.
    assign o_in_stall = (phase != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign in_ok      = ({1'b0, i_in_data.from_node} < n_full)
                     && ({1'b0, i_in_data.to_node} < n_full)
                     && (r_total < EW'(MAX_ENTRIES));
    assign o_cfg_ready = 1'b1;

    // Fields of the entry read back from the entry memory.
    assign e_src = r_edge_q[2*NODE_W-1:NODE_W];
    assign e_tgt = r_edge_q[NODE_W-1:0];
    assign e_ok  = ({1'b0, e_src} < n_full) && ({1'b0, e_tgt} < n_full);

    // Loop end flags.
    assign last_i    = (r_i == n_last);
    assign last_e    = (r_e == EAW'(r_total - EW'(1)));
    assign last_d    = (r_d == r_maxd);
    assign out_taken = r_out_valid && !i_out_stall;

    assign o_status.in_last    = in_take && i_in_data.last_item;
    assign o_status.last_i     = last_i;
    assign o_status.last_e     = last_e;
    assign o_status.last_d     = last_d;
    assign o_status.total_zero = (r_total == '0);
    assign o_status.edge_hit   = (e_src == NODE_W'(r_v)) && ({1'b0, e_tgt} < n_full);
    assign o_status.du_gt      = (r_dv < r_deg_q);
    assign o_status.w_eq_u     = (r_ord_q == r_u);
    assign o_status.out_taken  = out_taken;

    // Memory read addresses per phase.
    always_comb begin
        deg_ra = r_i;
        bkt_ra = r_d;
        ord_ra = r_i;
        pos_ra = r_u;
        case (phase)
            S_CNT_CHK:         deg_ra = e_src[NW-1:0];
            S_PK_RD, S_OUT_RD: deg_ra = r_ord_q;
            S_PK_EC:           deg_ra = e_tgt[NW-1:0];
            default:           deg_ra = r_i;
        endcase
        case (phase)
            S_BC_RB, S_PL_RB, S_PK_DU: bkt_ra = r_deg_q;
            default:                   bkt_ra = r_d;
        endcase
        if (phase == S_PK_BW) begin
            ord_ra = r_bkt_q[NW-1:0];
        end
        if (phase == S_PK_PU) begin
            pos_ra = r_w;
        end
    end

    // Memory writes per phase.
    always_comb begin
        edge_we = in_take && i_in_data.has_edge && in_ok;
        edge_wa = r_total[EAW-1:0];
        deg_we  = 1'b0;
        deg_wa  = r_i;
        deg_wd  = '0;
        bkt_we  = 1'b0;
        bkt_wa  = r_d;
        bkt_wd  = '0;
        pos_we  = 1'b0;
        pos_wa  = r_i;
        pos_wd  = r_bkt_q[NW-1:0];
        ord_we  = 1'b0;
        ord_wa  = r_bkt_q[NW-1:0];
        ord_wd  = r_i;
        case (phase)
            S_DCLR: begin
                deg_we = 1'b1;
            end
            S_CNT_WR: begin
                deg_we = e_ok;
                deg_wa = e_src[NW-1:0];
                deg_wd = r_deg_q + DW'(1);
            end
            S_PK_UPD: begin
                deg_we = 1'b1;
                deg_wa = r_u;
                deg_wd = r_du - DW'(1);
                bkt_we = 1'b1;
                bkt_wa = r_du;
                bkt_wd = r_bv + NCW'(1);
            end
            S_BCLR: begin
                bkt_we = 1'b1;
            end
            S_BC_WR: begin
                bkt_we = 1'b1;
                bkt_wa = r_deg_q;
                bkt_wd = r_bkt_q + NCW'(1);
            end
            S_PF_WR, S_SH_WR: begin
                bkt_we = 1'b1;
                bkt_wd = r_acc;
            end
            S_PL_WR: begin
                bkt_we = 1'b1;
                bkt_wa = r_deg_q;
                bkt_wd = r_bkt_q + NCW'(1);
                pos_we = 1'b1;
                ord_we = 1'b1;
            end
            S_PK_PW: begin
                ord_we = 1'b1;
                ord_wa = r_pu;
                ord_wd = r_w;
                pos_we = 1'b1;
                pos_wa = r_u;
                pos_wd = r_pos_q;
            end
            S_PK_SW: begin
                ord_we = 1'b1;
                ord_wa = r_pwp;
                ord_wd = r_u;
                pos_we = 1'b1;
                pos_wa = r_w;
                pos_wd = r_pu;
            end
            default: begin
                deg_we = 1'b0;
            end
        endcase
    end

    // Memories with a write port and a separate registered read port.
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_edge[edge_wa] <= {i_in_data.from_node, i_in_data.to_node};
        end
        r_edge_q <= m_edge[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            m_deg[deg_wa] <= deg_wd;
        end
        r_deg_q <= m_deg[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            m_bkt[bkt_wa] <= bkt_wd;
        end
        r_bkt_q <= m_bkt[bkt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            m_pos[pos_wa] <= pos_wd;
        end
        r_pos_q <= m_pos[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            m_ord[ord_wa] <= ord_wd;
        end
        r_ord_q <= m_ord[ord_ra];
    end

    // Control registers: configuration, loader, loop counters, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_W'(CFG_RESET);
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_e         <= '0;
            r_d         <= '0;
            r_maxd      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            case (phase)
                S_IDLE: begin
                    if (in_take && i_in_data.has_edge) begin
                        if (in_ok) begin
                            r_total <= r_total + EW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_DCLR: begin
                    r_i    <= last_i ? '0 : r_i + NW'(1);
                    r_maxd <= '0;
                end
                S_CNT_WR, S_PK_EN: begin
                    r_e <= last_e ? '0 : r_e + EAW'(1);
                end
                S_MX_UP: begin
                    if (r_deg_q > r_maxd) begin
                        r_maxd <= r_deg_q;
                    end
                    r_i <= last_i ? '0 : r_i + NW'(1);
                end
                S_BCLR: begin
                    r_d   <= last_d ? '0 : r_d + DW'(1);
                    r_acc <= '0;
                end
                S_BC_WR, S_PK_NEXT: begin
                    r_i <= last_i ? '0 : r_i + NW'(1);
                end
                S_PF_WR: begin
                    r_acc <= r_acc + r_bkt_q;
                    r_d   <= last_d ? '0 : r_d + DW'(1);
                end
                S_PL_WR: begin
                    r_acc <= '0;
                    r_i   <= last_i ? '0 : r_i + NW'(1);
                end
                S_SH_WR: begin
                    r_acc <= r_bkt_q;
                    r_d   <= last_d ? '0 : r_d + DW'(1);
                end
                S_OUT_LD: begin
                    r_out_valid <= 1'b1;
                end
                S_OUT_WT: begin
                    if (out_taken) begin
                        r_out_valid <= 1'b0;
                        r_i <= last_i ? '0 : r_i + NW'(1);
                        if (last_i) begin
                            r_total <= '0;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    // Payload registers of the peeling step and the result.
    always_ff @(posedge i_clk) begin
        case (phase)
            S_PK_RD, S_OUT_RD: r_v <= r_ord_q;
            S_PK_DV:           r_dv <= r_deg_q;
            S_PK_EC:           r_u <= e_tgt[NW-1:0];
            S_PK_DU:           r_du <= r_deg_q;
            S_PK_BW:           r_bv <= r_bkt_q;
            S_PK_W:            r_w <= r_ord_q;
            S_PK_PU:           r_pu <= r_pos_q;
            S_PK_PW:           r_pwp <= r_pos_q;
            S_OUT_LD: begin
                r_out.rank        <= NODE_W'(r_i);
                r_out.node        <= NODE_W'(r_v);
                r_out.core_number <= CORE_W'(r_deg_q);
                r_out.dropped     <= r_ovf;
                r_out.last_result <= last_i;
            end
            default: begin
                r_v <= r_v;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/kcore_decomposition.sv @@
// K-core decomposition top level: joins the controller and the datapath.
// Depends on kcd_pkg, kcd_ctrl, kcd_datapath and the assertion macro header.
`include "kcore_decomposition_assert.svh"

// Adjacency entries load at one transaction per cycle while the block is
// idle. The transaction marked last starts the computation, during which
// the input is stalled: a degree clear over every node, a degree recount
// over every held entry, bucket passes over every node and over every
// degree value up to the largest degree, and the peeling pass, which visits
// every node and scans every held entry for every node, with extra steps
// for an entry that lowers a degree. Each result is then held until the
// output is not stalled. The passes run through the entry, degree, bucket,
// position and order memories, each with a write port and a separate port
// giving one registered read per cycle.
module kcore_decomposition
    import kcd_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    kcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Memories, counters and the result register.
    kcd_datapath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // A result is only presented while the sequencer waits for it to be taken.
    `KCD_ASSERT_SAME(a_out_in_wait, o_out_valid, w_cmd.phase == S_OUT_WT, "result outside wait")
    // No input transaction is taken while a computation runs.
    `KCD_ASSERT_SAME(a_busy_stalls, w_cmd.phase != S_IDLE, o_in_stall, "input open while busy")
    // Taking the final result returns the block to idle.
    `KCD_ASSERT_NEXT(a_end_idle, o_out_valid && !i_out_stall && o_out_data.last_result, w_cmd.phase == S_IDLE, "no idle after final result")

endmodule

@@ tb/sv/tb_kcore_decomposition.sv @@
// Self-checking testbench for kcore_decomposition: random graphs, node count changes, stalls.
// Depends on kcd_pkg and the kcore_decomposition RTL only.
`timescale 1ns / 1ps

import kcd_pkg::*;

// Scoreboard: tracks the loaded graph and predicts the ordering and core numbers.
class kcore_scoreboard;
    localparam int NODES   = 64;
    localparam int ENTRIES = 1024;

    int unsigned node_count_reg = CFG_RESET;
    bit [5:0]    entry_from[ENTRIES];
    bit [5:0]    entry_to[ENTRIES];
    int unsigned entry_total;
    bit          drop_seen;
    t_out_item   expected_q[$];
    int unsigned mismatches;

    // Records an accepted input transaction and queues any results it causes.
    function void note_item(t_in_item it);
        int unsigned n, e, i, d, maxd, start, cnt, p, v, u, du, pw, w, pu;
        int unsigned degree[NODES];
        int unsigned bstart[ENTRIES + 1];
        int unsigned position[NODES];
        int unsigned order[NODES];
        t_out_item   res;
        n = node_count_reg;
        if (n == 0) n = 1;
        if (n > NODES) n = NODES;
        if (it.has_edge) begin
            if (it.from_node >= n || it.to_node >= n || entry_total >= ENTRIES) begin
                drop_seen = 1'b1;
            end else begin
                entry_from[entry_total] = it.from_node;
                entry_to[entry_total]   = it.to_node;
                entry_total++;
            end
        end
        if (!it.last_item) return;

        // Recount degrees from entries still inside the node range.
        for (i = 0; i < NODES; i++) degree[i] = 0;
        for (e = 0; e < entry_total; e++)
            if (entry_from[e] < n && entry_to[e] < n) degree[entry_from[e]]++;
        maxd = 0;
        for (i = 0; i < n; i++) if (degree[i] > maxd) maxd = degree[i];

        // Bucket sort by degree, ties in node order.
        for (d = 0; d <= maxd; d++) bstart[d] = 0;
        for (i = 0; i < n; i++) bstart[degree[i]]++;
        start = 0;
        for (d = 0; d <= maxd; d++) begin
            cnt = bstart[d];
            bstart[d] = start;
            start += cnt;
        end
        for (i = 0; i < n; i++) begin
            p = bstart[degree[i]] % NODES;
            position[i] = p;
            order[p] = i;
            bstart[degree[i]]++;
        end
        for (d = maxd; d > 0; d--) bstart[d] = bstart[d - 1];
        bstart[0] = 0;

        // Peel nodes in order, lowering higher-degree neighbours.
        for (i = 0; i < n; i++) begin
            v = order[i] % NODES;
            for (e = 0; e < entry_total; e++) begin
                if (entry_from[e] != v || entry_to[e] >= n) continue;
                u = entry_to[e];
                if (degree[v] >= degree[u]) continue;
                du = degree[u];
                pw = bstart[du] % NODES;
                w = order[pw] % NODES;
                if (w != u) begin
                    pu = position[u];
                    order[pu % NODES] = w;
                    order[position[w] % NODES] = u;
                    position[u] = position[w];
                    position[w] = pu;
                end
                bstart[du]++;
                degree[u] = du - 1;
            end
        end

        for (i = 0; i < n; i++) begin
            v = order[i] % NODES;
            res.rank        = i[5:0];
            res.node        = v[5:0];
            res.core_number = degree[v][10:0];
            res.dropped     = drop_seen;
            res.last_result = (i + 1 == n);
            expected_q = {expected_q, res};
        end
        entry_total = 0;
        drop_seen   = 1'b0;
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_result(t_out_item got);
        t_out_item exp_item;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result rank=%0d node=%0d core=%0d",
                         got.rank, got.node, got.core_number);
            return;
        end
        exp_item = expected_q.pop_front();
        if (got !== exp_item) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: expected rank=%0d node=%0d core=%0d drop=%0b last=%0b",
                         exp_item.rank, exp_item.node, exp_item.core_number,
                         exp_item.dropped, exp_item.last_result);
                $display("       got      rank=%0d node=%0d core=%0d drop=%0b last=%0b",
                         got.rank, got.node, got.core_number, got.dropped, got.last_result);
            end
        end
    endfunction
endclass

module tb_kcore_decomposition;
    localparam int CYCLE_LIMIT = 5000000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b1;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    kcore_scoreboard sb = new();
    int unsigned     cycles;
    bit              hold_request;
    bit              no_gaps;
    int unsigned     items_sent;

    kcore_decomposition dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output monitor: a transaction is taken at the next edge when valid and not stalled.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // Receiver: random stall per result, plus one long hold-off on request.
    initial begin
        int unsigned k;
        @(posedge i_rst_n);
        forever begin
            k = no_gaps ? 0 : $urandom_range(0, 18);
            if (hold_request) begin
                k = 700;
                hold_request = 1'b0;
            end
            if (k > 0) begin
                i_out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    // Sends one input transaction after an optional gap; leaves valid high.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_fields(input int unsigned f, input int unsigned t,
                               input bit has, input bit lst);
        t_in_item it;
        it.from_node = f[5:0];
        it.to_node   = t[5:0];
        it.has_edge  = has;
        it.last_item = lst;
        send_item(it);
    endtask

    // Writes node_count once the block is idle.
    task automatic write_node_count(input int unsigned value);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[CFG_W-1:0];
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.node_count_reg = value;
    endtask

    // Random graph: mostly in-range entries over a dense node subset, some noise.
    task automatic send_random_graph(input int unsigned n, input int unsigned entries);
        int unsigned span, j, f, t;
        span = (n > 12) ? $urandom_range(4, n) : n;
        for (j = 0; j < entries; j++) begin
            f = $urandom_range(0, span - 1);
            t = $urandom_range(0, span - 1);
            if ($urandom_range(0, 9) == 0) begin
                f = $urandom_range(0, 63);
                t = $urandom_range(0, 63);
            end
            send_fields(f, t, $urandom_range(0, 9) != 0, 1'b0);
        end
        send_fields($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                    $urandom_range(0, 1) == 1, 1'b1);
    endtask

    initial begin
        int unsigned g, n, cfg, j;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: four nodes with a self loop, duplicates, drops and bare items.
        write_node_count(4);
        send_fields(0, 1, 1'b1, 1'b0);
        send_fields(1, 0, 1'b1, 1'b0);
        send_fields(1, 2, 1'b1, 1'b0);
        send_fields(1, 2, 1'b1, 1'b0);
        send_fields(2, 2, 1'b1, 1'b0);
        send_fields(2, 1, 1'b1, 1'b0);
        send_fields(4, 0, 1'b1, 1'b0);
        send_fields(0, 63, 1'b1, 1'b0);
        send_fields(63, 63, 1'b0, 1'b0);
        send_fields(3, 0, 1'b1, 1'b1);
        // Count of zero acts as one node; a bare end marker alone.
        write_node_count(0);
        send_fields(0, 0, 1'b0, 1'b1);
        // Count above the maximum acts as 64; extreme node ids.
        write_node_count(127);
        send_fields(63, 0, 1'b1, 1'b0);
        send_fields(0, 63, 1'b1, 1'b0);
        send_fields(63, 63, 1'b1, 1'b1);
        // Count lowered while loading drops held entries at the new limit.
        write_node_count(64);
        send_fields(10, 3, 1'b1, 1'b0);
        send_fields(3, 10, 1'b1, 1'b0);
        send_fields(3, 5, 1'b1, 1'b0);
        write_node_count(8);
        send_fields(5, 3, 1'b1, 1'b1);

        // Random graphs; one of them meets a long receiver hold-off.
        g = 0;
        while (items_sent < 410) begin
            case ($urandom_range(0, 5))
                0: cfg = 1;
                1: cfg = 64;
                2: cfg = $urandom_range(65, 127);
                3: cfg = 0;
                default: cfg = $urandom_range(2, 20);
            endcase
            write_node_count(cfg);
            n = (cfg == 0) ? 1 : ((cfg > 64) ? 64 : cfg);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (g == 3) hold_request = 1'b1;
            if (g == 5) begin
                send_random_graph(n, 6);
                write_node_count($urandom_range(1, 64));
                send_random_graph($urandom_range(1, 64), 8);
            end else begin
                send_random_graph(n, $urandom_range(0, 30));
            end
            if (g == 3) begin
                for (j = 0; j < 10; j++)
                    send_fields($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                1'b1, 1'b0);
                send_fields(0, 0, 1'b0, 1'b1);
            end
            g++;
        end
        i_in_valid <= 1'b0;
        no_gaps = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/kcd_pkg.sv
rtl/core/kcd_ctrl.sv
rtl/core/kcd_datapath.sv
rtl/core/kcore_decomposition.sv
tb/sv/tb_kcore_decomposition.sv
